[rtl/core/assert_macros.svh]
// Assertion macros for the RTL files of the code matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define DCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define DCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/dcm_pkg.sv]
// Types and constants of the dual code matcher.
package dcm_pkg;

    // Input word: a scanner character or a millisecond tick
    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [1:0] verdict;
        logic       reject_active;
    } t_out_word;

    // Timing registers handed from the register file to the matcher
    typedef struct packed {
        logic [15:0] idle_timeout_ticks;
        logic [15:0] reject_pulse_ticks;
    } t_timing;

    // Word kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Verdict codes
    localparam logic [1:0] VERDICT_NONE     = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
    localparam logic [1:0] VERDICT_REJECTED = 2'd2;

    // Characters
    localparam logic [7:0] CHAR_CR   = 8'd13;
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;

    // Counter limits
    localparam logic [15:0] CNT_MAX = 16'hFFFF;
    localparam logic [3:0]  POS_MAX = 4'd15;

    // Register file
    localparam int          CFG_IDX_W       = 8;
    localparam logic [7:0]  REG_CODE_A      = 8'd0;
    localparam logic [7:0]  REG_CODE_B      = 8'd1;
    localparam logic [7:0]  REG_IDLE_TICKS  = 8'd2;
    localparam logic [7:0]  REG_PULSE_TICKS = 8'd3;
    localparam logic [15:0] IDLE_TICKS_RST  = 16'd200;
    localparam logic [15:0] PULSE_TICKS_RST = 16'd500;

endpackage

[rtl/core/dcm_cfg.sv]
// Configuration register file: two stored codes and two tick counts.
module dcm_cfg
    import dcm_pkg::*;
#(
    parameter int CODE_DIGITS = 13,
    parameter int CFG_W       = 52
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  logic [CFG_IDX_W-1:0]   i_index,
    input  logic [CFG_W-1:0]       i_data,
    output logic [4*CODE_DIGITS-1:0] o_code_a,
    output logic [4*CODE_DIGITS-1:0] o_code_b,
    output t_timing                o_timing
);

    localparam int CODE_W = 4 * CODE_DIGITS;

    logic [CODE_W-1:0] r_code_a;
    logic [CODE_W-1:0] r_code_b;
    t_timing           r_timing;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_a                    <= '0;
            r_code_b                    <= '0;
            r_timing.idle_timeout_ticks <= IDLE_TICKS_RST;
            r_timing.reject_pulse_ticks <= PULSE_TICKS_RST;
        end else if (i_wr) begin
            case (i_index)
                REG_CODE_A:      r_code_a <= i_data[CODE_W-1:0];
                REG_CODE_B:      r_code_b <= i_data[CODE_W-1:0];
                REG_IDLE_TICKS:  r_timing.idle_timeout_ticks <= i_data[15:0];
                REG_PULSE_TICKS: r_timing.reject_pulse_ticks <= i_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_code_a = r_code_a;
    assign o_code_b = r_code_b;
    assign o_timing = r_timing;

endmodule

[rtl/core/dcm_match.sv]
// Match state and single-pass update for one word: position, flags, timers.
module dcm_match
    import dcm_pkg::*;
#(
    parameter int CODE_DIGITS = 13
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  t_in_word                 i_word,
    input  logic [4*CODE_DIGITS-1:0] i_code_a,
    input  logic [4*CODE_DIGITS-1:0] i_code_b,
    input  t_timing                  i_timing,
    output t_out_word                o_result
);

    logic [3:0]  r_position, n_position;
    logic        r_mismatch_a, n_mismatch_a;
    logic        r_mismatch_b, n_mismatch_b;
    logic [15:0] r_idle_count, n_idle_count;
    logic [15:0] r_pulse_rem, n_pulse_rem;

    logic [3:0] pos_base;
    logic [3:0] digit;
    logic [3:0] nib_a;
    logic [3:0] nib_b;
    logic       is_digit;
    logic       in_range;
    logic [1:0] verdict;

    // Stored digit at the current position
    always_comb begin
        nib_a = '0;
        nib_b = '0;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            if (pos_base == 4'(i)) begin
                nib_a = i_code_a[4*i +: 4];
                nib_b = i_code_b[4*i +: 4];
            end
        end
    end

    // Next state for this word
    always_comb begin
        n_position   = r_position;
        n_mismatch_a = r_mismatch_a;
        n_mismatch_b = r_mismatch_b;
        n_idle_count = r_idle_count;
        n_pulse_rem  = r_pulse_rem;
        verdict      = VERDICT_NONE;

        // position restarts after too long a silence
        pos_base = (r_idle_count > i_timing.idle_timeout_ticks) ? 4'd0 : r_position;
        is_digit = (i_word.char_code >= CHAR_ZERO) && (i_word.char_code <= CHAR_NINE);
        digit    = 4'(i_word.char_code - CHAR_ZERO);
        in_range = pos_base < 4'(CODE_DIGITS);

        if (i_word.kind == KIND_TICK) begin
            if (r_idle_count != CNT_MAX) begin
                n_idle_count = r_idle_count + 16'd1;
            end
            if (r_pulse_rem != 16'd0) begin
                n_pulse_rem = r_pulse_rem - 16'd1;
            end
        end else begin
            n_idle_count = '0;
            n_position   = pos_base;
            if (is_digit) begin
                // a digit past the code end fails both codes
                if (!in_range || (nib_a != digit)) begin
                    n_mismatch_a = 1'b1;
                end
                if (!in_range || (nib_b != digit)) begin
                    n_mismatch_b = 1'b1;
                end
            end
            if (i_word.char_code != CHAR_CR) begin
                if (pos_base != POS_MAX) begin
                    n_position = pos_base + 4'd1;
                end
            end else begin
                if (!n_mismatch_a || !n_mismatch_b) begin
                    verdict = VERDICT_ACCEPTED;
                end else begin
                    verdict     = VERDICT_REJECTED;
                    n_pulse_rem = i_timing.reject_pulse_ticks;
                end
                n_mismatch_a = 1'b0;
                n_mismatch_b = 1'b0;
                n_position   = '0;
            end
        end
    end

    // State update on each processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position   <= '0;
            r_mismatch_a <= 1'b0;
            r_mismatch_b <= 1'b0;
            r_idle_count <= CNT_MAX;
            r_pulse_rem  <= '0;
        end else if (i_adv) begin
            r_position   <= n_position;
            r_mismatch_a <= n_mismatch_a;
            r_mismatch_b <= n_mismatch_b;
            r_idle_count <= n_idle_count;
            r_pulse_rem  <= n_pulse_rem;
        end
    end

    assign o_result.verdict       = verdict;
    assign o_result.reject_active = (n_pulse_rem != 16'd0);

endmodule

[rtl/core/dual_code_match_reject.sv]
// Top level of the dual code matcher with timed reject output.
//
// Takes scanner characters and millisecond ticks, one word per cycle, and
// returns one result word for each. Every digit is checked at its position
// against two stored codes of CODE_DIGITS BCD digits; a carriage return
// accepts the code when either stored code still matches, otherwise it
// rejects and drives reject_active for reject_pulse_ticks ticks. A character
// after more than idle_timeout_ticks ticks of silence restarts the position.
// Throughput is one word per cycle with no stalls while the result side takes
// its words. A word accepted into the input register goes through the
// combinational state update and is loaded into the result register when it
// advances, and its result word is valid from then on. The input stalls only
// when both registers are full and the result side stalls. The configuration
// port is always ready; write it only while no words are in flight.
`include "assert_macros.svh"

module dual_code_match_reject
    import dcm_pkg::*;
#(
    parameter int CODE_DIGITS = 13
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // input words
    input  logic     i_in_valid,
    input  t_in_word i_in_word,
    output logic     o_in_stall,
    // result words
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [((4*CODE_DIGITS > 16) ? 4*CODE_DIGITS : 16)-1:0] i_cfg_data
);

    localparam int CODE_W = 4 * CODE_DIGITS;
    localparam int CFG_W  = (CODE_W > 16) ? CODE_W : 16;

    logic [CODE_W-1:0] code_a;
    logic [CODE_W-1:0] code_b;
    t_timing           timing;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word result;
    logic      in_accept;
    logic      adv;

    // Handshakes: a word moves on when the result slot is free or draining
    assign adv         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !adv;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Register file
    dcm_cfg #(
        .CODE_DIGITS (CODE_DIGITS),
        .CFG_W       (CFG_W)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (i_cfg_valid && o_cfg_ready),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_code_a (code_a),
        .o_code_b (code_b),
        .o_timing (timing)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
    end

    // Match state and update
    dcm_match #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_word   (r_in_word),
        .i_code_a (code_a),
        .i_code_b (code_b),
        .i_timing (timing),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Checks
    `DCM_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, r_in_valid)
    `DCM_ASSERT_IMP(a_verdict_code, i_clk, i_rst_n, r_out_valid,
        (r_out_word.verdict == VERDICT_NONE) || (r_out_word.verdict == VERDICT_ACCEPTED)
        || (r_out_word.verdict == VERDICT_REJECTED))
    `DCM_ASSERT_NXT(a_tick_no_verdict, i_clk, i_rst_n,
        adv && (r_in_word.kind == KIND_TICK),
        r_out_valid && (r_out_word.verdict == VERDICT_NONE))
    `DCM_ASSERT_NXT(a_reject_drives_pulse, i_clk, i_rst_n,
        adv && (result.verdict == VERDICT_REJECTED) && (timing.reject_pulse_ticks != 16'd0),
        r_out_word.reject_active)

endmodule
